// ===== rtl/sdfd_pkg.sv =====
package sdfd_pkg;

   localparam int unsigned FRAME_MIN_BYTES = 22;
   localparam int unsigned POS_W           = 5;
   localparam int unsigned SUM_W           = 20;
   localparam int unsigned RATE_W          = 14;
   localparam int unsigned WEIGHT_W        = 17;
   localparam int unsigned RSP_DATA_W      = 64;

   localparam logic [7:0] SYNC_CODE = 8'hFF;
   localparam logic [7:0] ADDR_CODE = 8'h10;

   localparam logic [POS_W-1:0] VOL_FIRST  = POS_W'(2);
   localparam logic [POS_W-1:0] TOT_FIRST  = POS_W'(8);
   localparam logic [POS_W-1:0] TOT_END    = POS_W'(14);
   localparam logic [POS_W-1:0] ADDR_POS   = POS_W'(15);
   localparam logic [POS_W-1:0] RATE_FIRST = POS_W'(16);
   localparam logic [POS_W-1:0] RATE_END   = POS_W'(20);
   localparam logic [POS_W-1:0] POS_FULL   = POS_W'(FRAME_MIN_BYTES);

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_SYNC  = 3'd1,
      ST_DIGIT = 3'd2,
      ST_SHORT = 3'd3,
      ST_FAULT = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
      logic       capture_fault;
   } item_type;

   typedef struct packed {
      logic       bad;
      logic [3:0] value;
   } digit_type;

   // bit0 is the decimal point; blank counts as zero
   function automatic digit_type main_digit(input logic [7:0] raw);
      digit_type d;
      d = '{bad: 1'b0, value: 4'd0};
      unique case (raw & 8'hFE)
         8'hFC: d.value = 4'd0;
         8'h60: d.value = 4'd1;
         8'hDA: d.value = 4'd2;
         8'hF2: d.value = 4'd3;
         8'h66: d.value = 4'd4;
         8'hB6: d.value = 4'd5;
         8'hBE: d.value = 4'd6;
         8'hE0: d.value = 4'd7;
         8'hFE: d.value = 4'd8;
         8'hE6: d.value = 4'd9;
         8'h00: d.value = 4'd0;
         default: d.bad = 1'b1;
      endcase
      return d;
   endfunction

   // bit7 is the decimal point
   function automatic digit_type rate_digit(input logic [7:0] raw);
      digit_type d;
      d = '{bad: 1'b0, value: 4'd0};
      unique case (raw & 8'h7F)
         8'h3F: d.value = 4'd0;
         8'h06: d.value = 4'd1;
         8'h5B: d.value = 4'd2;
         8'h4F: d.value = 4'd3;
         8'h66: d.value = 4'd4;
         8'h6D: d.value = 4'd5;
         8'h7D: d.value = 4'd6;
         8'h07: d.value = 4'd7;
         8'h7F: d.value = 4'd8;
         8'h6F: d.value = 4'd9;
         default: d.bad = 1'b1;
      endcase
      return d;
   endfunction

   function automatic logic [WEIGHT_W-1:0] weight6(input logic [2:0] idx);
      logic [WEIGHT_W-1:0] w;
      unique case (idx)
         3'd0: w = WEIGHT_W'(1);
         3'd1: w = WEIGHT_W'(10);
         3'd2: w = WEIGHT_W'(100);
         3'd3: w = WEIGHT_W'(1000);
         3'd4: w = WEIGHT_W'(10000);
         3'd5: w = WEIGHT_W'(100000);
         default: w = '0;
      endcase
      return w;
   endfunction

   // digit times a power of ten, wrapped to SUM_W bits
   function automatic logic [SUM_W-1:0] weigh(input logic [3:0] value,
                                              input logic [2:0] idx);
      logic [SUM_W-1:0] v;
      logic [SUM_W-1:0] w;
      v = {{(SUM_W-4){1'b0}}, value};
      w = {{(SUM_W-WEIGHT_W){1'b0}}, weight6(idx)};
      return v * w;
   endfunction

endpackage

// ===== rtl/segment_display_frame_decoder.sv =====
// Channel  Dir  Word                      Sideband
// req      in   tdata[7:0] bus byte       tlast frame end, tuser capture fault
// rsp      out  tdata[63:0] frame result  none
//
// One byte per cycle unless a frame end waits on a stalled result; each byte
// is registered, then decoded through a segment table and added into the
// frame sums. A frame result is registered on rsp when its last byte leaves
// the input register. Reset is synchronous and clears the frame state and
// both valid stages. A stalled result holds rsp and stops the next frame end
// in the input register and bytes behind it; earlier ones still reach the sums.
module segment_display_frame_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // frame_end
   input  logic        req_tuser,   // capture_fault
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [19:0] volume, [39:20] total, [53:40] rate,
                                    // [56:54] status, [63:57] zero
);
   import sdfd_pkg::*;

   item_type req_item;
   item_type item;
   logic     item_valid;
   logic     take;

   assign req_item = '{data_byte: req_tdata, frame_end: req_tlast,
                       capture_fault: req_tuser};

   sdfd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   sdfd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/sdfd_in_reg.sv =====
module sdfd_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  sdfd_pkg::item_type  req_item,
   input  logic                take,
   output logic                item_valid,
   output sdfd_pkg::item_type  item
);
   import sdfd_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     load;

   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;
   assign valid_in   = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/sdfd_decode.sv =====
module sdfd_decode (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           item_valid,
   input  sdfd_pkg::item_type             item,
   output logic                           take,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sdfd_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sdfd_pkg::*;

   logic [POS_W-1:0]  pos_ff,       pos_in;
   logic [SUM_W-1:0]  vol_ff,       vol_in;
   logic [SUM_W-1:0]  tot_ff,       tot_in;
   logic [RATE_W-1:0] rate_ff,      rate_in;
   logic              sync_bad_ff,  sync_bad_in;
   logic              digit_bad_ff, digit_bad_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  rsp_vol_ff,   rsp_vol_in;
   logic [SUM_W-1:0]  rsp_tot_ff,   rsp_tot_in;
   logic [RATE_W-1:0] rsp_rate_ff,  rsp_rate_in;
   status_type        rsp_status_ff, rsp_status_in;

   digit_type         mdig;
   digit_type         rdig;
   logic [SUM_W-1:0]  vol_add;
   logic [SUM_W-1:0]  tot_add;
   logic [SUM_W-1:0]  rate_add;
   logic [SUM_W-1:0]  vol_next;
   logic [SUM_W-1:0]  tot_next;
   logic [RATE_W-1:0] rate_next;
   logic [POS_W-1:0]  pos_next;
   logic              sync_next;
   logic              digit_next;
   logic              emit;

   assign take = item_valid && (!item.frame_end || !rsp_valid_ff || rsp_tready);
   assign emit = take && item.frame_end;

   assign mdig     = main_digit(item.data_byte);
   assign rdig     = rate_digit(item.data_byte);
   assign vol_add  = weigh(mdig.value, 3'(pos_ff - VOL_FIRST));
   assign tot_add  = weigh(mdig.value, 3'(pos_ff - TOT_FIRST));
   assign rate_add = weigh(rdig.value, 3'(pos_ff - RATE_FIRST));

   always_comb begin
      vol_next   = vol_ff;
      tot_next   = tot_ff;
      rate_next  = rate_ff;
      sync_next  = sync_bad_ff;
      digit_next = digit_bad_ff;
      pos_next   = pos_ff;
      if (pos_ff < POS_FULL) begin
         pos_next = pos_ff + POS_W'(1);
         priority if (pos_ff < VOL_FIRST) begin
            if (item.data_byte != SYNC_CODE) sync_next = 1'b1;
         end else if (pos_ff < TOT_FIRST) begin
            if (mdig.bad) digit_next = 1'b1;
            else          vol_next   = vol_ff + vol_add;
         end else if (pos_ff < TOT_END) begin
            if (mdig.bad) digit_next = 1'b1;
            else          tot_next   = tot_ff + tot_add;
         end else if (pos_ff == ADDR_POS) begin
            if (item.data_byte != ADDR_CODE) sync_next = 1'b1;
         end else if (pos_ff >= RATE_FIRST && pos_ff < RATE_END) begin
            if (rdig.bad) digit_next = 1'b1;
            else          rate_next  = rate_ff + rate_add[RATE_W-1:0];
         end else begin
            // bytes 14, 20 and 21 are only counted
            pos_next = pos_ff + POS_W'(1);
         end
      end
   end

   always_comb begin
      priority if (item.capture_fault)  rsp_status_in = ST_FAULT;
      else if (pos_next < POS_FULL)     rsp_status_in = ST_SHORT;
      else if (sync_next)               rsp_status_in = ST_SYNC;
      else if (digit_next)              rsp_status_in = ST_DIGIT;
      else                              rsp_status_in = ST_OK;
   end

   assign rsp_vol_in  = (rsp_status_in == ST_OK) ? vol_next  : '0;
   assign rsp_tot_in  = (rsp_status_in == ST_OK) ? tot_next  : '0;
   assign rsp_rate_in = (rsp_status_in == ST_OK) ? rate_next : '0;

   // frame end puts the accumulators back to their reset values
   assign pos_in       = !take ? pos_ff       : (item.frame_end ? '0   : pos_next);
   assign vol_in       = !take ? vol_ff       : (item.frame_end ? '0   : vol_next);
   assign tot_in       = !take ? tot_ff       : (item.frame_end ? '0   : tot_next);
   assign rate_in      = !take ? rate_ff      : (item.frame_end ? '0   : rate_next);
   assign sync_bad_in  = !take ? sync_bad_ff  : (!item.frame_end && sync_next);
   assign digit_bad_in = !take ? digit_bad_ff : (!item.frame_end && digit_next);
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         vol_ff       <= '0;
         tot_ff       <= '0;
         rate_ff      <= '0;
         sync_bad_ff  <= 1'b0;
         digit_bad_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         vol_ff       <= vol_in;
         tot_ff       <= tot_in;
         rate_ff      <= rate_in;
         sync_bad_ff  <= sync_bad_in;
         digit_bad_ff <= digit_bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_vol_ff    <= rsp_vol_in;
         rsp_tot_ff    <= rsp_tot_in;
         rsp_rate_ff   <= rsp_rate_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2*SUM_W-RATE_W-3){1'b0}},
                        rsp_status_ff, rsp_rate_ff, rsp_tot_ff, rsp_vol_ff};

endmodule

// ===== rtl/sdfd_checker.sv =====
module sdfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tlast,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);
   import sdfd_pkg::*;

   logic [2:0] status;
   assign status  = rsp_tdata[56:54];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status != ST_OK |-> rsp_tdata[53:0] == 54'd0 && rsp_tdata[63:57] == 7'd0)
      else $error("failed frame carries nonzero values");

   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == ST_OK |->
         rsp_tdata[19:0] <= 20'd999999 && rsp_tdata[39:20] <= 20'd999999 &&
         rsp_tdata[53:40] <= 14'd9999 && rsp_tdata[63:57] == 7'd0)
      else $error("good frame value out of range");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind segment_display_frame_decoder sdfd_checker u_sdfd_checker (.*);
